[src/sgs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgs_pkg
// Shared types, constants and tap table of the separable gaussian smoother.
// ----------------------------------------------------------------------------
package sgs_pkg;

  localparam int TAPS       = 17;
  localparam int RADIUS     = TAPS / 2;
  localparam int STORE_ROWS = 2 * RADIUS;
  localparam int ROW_W      = $clog2(STORE_ROWS);
  localparam int PIX_W      = 16;
  localparam int TAP_W      = 13;
  localparam int ACC_W      = 33;
  localparam int IDX_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIM_CFG_W  = 9;
  localparam int DIM_MIN    = 17;
  localparam int HALF       = 32768;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER = 2'd2;

  // item kinds
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] sample;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]       row;
    logic [7:0]       col;
    logic [PIX_W-1:0] value;
    logic             last;
  } out_beat_t;

  typedef struct packed {
    logic             load;
    logic             prep;
    logic             wrap;
    logic             div_step;
    logic             row_step;
    logic             col_step;
    logic             fin;
    logic [IDX_W-1:0] idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  function automatic logic [TAP_W-1:0] tap(input logic [IDX_W-1:0] k);
    logic [TAP_W-1:0] t;
    unique case (k)
      5'd0, 5'd16: t = 13'd915;
      5'd1, 5'd15: t = 13'd1462;
      5'd2, 5'd14: t = 13'd2195;
      5'd3, 5'd13: t = 13'd3095;
      5'd4, 5'd12: t = 13'd4100;
      5'd5, 5'd11: t = 13'd5103;
      5'd6, 5'd10: t = 13'd5966;
      5'd7, 5'd9:  t = 13'd6552;
      5'd8:        t = 13'd6760;
      default:     t = '0;
    endcase
    return t;
  endfunction

endpackage

[src/sgs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgs_div
// Restoring divider, one quotient bit per step; splits a raster position.
// ----------------------------------------------------------------------------
module sgs_div #(
  parameter int N_W = 17,
  parameter int D_W = 9
) (
  input  logic           clk_i,
  input  logic           load_i,
  input  logic           step_i,
  input  logic [N_W-1:0] dividend_i,
  input  logic [D_W-1:0] divisor_i,
  output logic [N_W-1:0] quot_o,
  output logic [D_W-1:0] rem_o
);

  logic [N_W-1:0] dvd_q, dvd_d;
  logic [D_W:0]   rem_q, rem_d;
  logic [D_W:0]   rem_sh;
  logic           take;

  always_comb begin
    rem_sh = {rem_q[D_W-1:0], dvd_q[N_W-1]};
    take   = rem_sh >= {1'b0, divisor_i};
    rem_d  = take ? rem_sh - {1'b0, divisor_i} : rem_sh;
    dvd_d  = {dvd_q[N_W-2:0], take};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (step_i) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign quot_o = dvd_q;
  assign rem_o  = rem_q[D_W-1:0];

endmodule

[src/sgs_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgs_datapath
// Config registers, positions, shared tap multiply-accumulate, row store.
// ----------------------------------------------------------------------------
module sgs_datapath #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sgs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sgs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  sgs_pkg::in_beat_t                  in_data_i,
  input  sgs_pkg::ctrl_cmd_t                 cmd_i,
  output sgs_pkg::dp_sts_t                   sts_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output sgs_pkg::out_beat_t                 out_data_o
);
  import sgs_pkg::*;

  localparam int W_W   = $clog2(MAX_WIDTH + 1);
  localparam int H_W   = $clog2(MAX_HEIGHT + 1);
  localparam int P_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int DEPTH = STORE_ROWS * MAX_WIDTH;
  localparam int A_W   = $clog2(DEPTH);

  logic [W_W-1:0]   width_q;
  logic [H_W-1:0]   height_q;
  logic [PIX_W-1:0] border_q;
  logic             op_q;
  logic [PIX_W-1:0] sample_q;
  logic [P_W-1:0]   total_q, lag_q;
  logic [P_W-1:0]   ipos_q, opos_q, backlog_q;
  logic [ACC_W-1:0] acc_row_q, acc_col_q;
  logic [PIX_W-1:0] win_q [STORE_ROWS];
  logic [PIX_W-1:0] rd_q;
  logic [PIX_W-1:0] store_q [DEPTH];
  out_beat_t        out_q;
  logic             out_valid_q;

  logic [P_W-1:0]   ipos_w, opos_w;
  logic [P_W-1:0]   r, y;
  logic [W_W-1:0]   c, x, hx;
  logic [TAP_W-1:0] mul_a;
  logic [PIX_W-1:0] mul_b;
  logic [TAP_W+PIX_W-1:0] prod;
  logic [ACC_W-1:0] rsum_row, rsum_col;
  logic [PIX_W-1:0] hval;
  logic             is_pix, h_ok, emit, inner, filt, out_free;
  logic [P_W-1:0]   bl_inc;
  logic [A_W-1:0]   raddr, waddr;
  logic [ROW_W-1:0] rrow;
  logic [31:0]      cfg_dim;

  // config writes, sizes saturated into the supported range
  assign cfg_dim = {{(32-DIM_CFG_W){1'b0}}, cfg_data_i[DIM_CFG_W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= W_W'((256 > MAX_WIDTH) ? MAX_WIDTH : 256);
      height_q <= H_W'((256 > MAX_HEIGHT) ? MAX_HEIGHT : 256);
      border_q <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WIDTH:  width_q  <= (cfg_dim < DIM_MIN) ? W_W'(DIM_MIN) :
                                (cfg_dim > MAX_WIDTH) ? W_W'(MAX_WIDTH) : W_W'(cfg_dim);
        REG_HEIGHT: height_q <= (cfg_dim < DIM_MIN) ? H_W'(DIM_MIN) :
                                (cfg_dim > MAX_HEIGHT) ? H_W'(MAX_HEIGHT) : H_W'(cfg_dim);
        REG_BORDER: border_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= in_data_i.op;
      sample_q <= in_data_i.sample;
    end
    if (cmd_i.prep) begin
      total_q <= P_W'(width_q) * P_W'(height_q);
      lag_q   <= (P_W'(width_q) << 3) + P_W'(RADIUS);
    end
  end

  assign ipos_w = (ipos_q >= total_q) ? '0 : ipos_q;
  assign opos_w = (opos_q >= total_q) ? '0 : opos_q;

  sgs_div #(.N_W(P_W), .D_W(W_W)) u_div_in (
    .clk_i      (clk_i),
    .load_i     (cmd_i.wrap),
    .step_i     (cmd_i.div_step),
    .dividend_i (ipos_w),
    .divisor_i  (width_q),
    .quot_o     (r),
    .rem_o      (c)
  );

  sgs_div #(.N_W(P_W), .D_W(W_W)) u_div_out (
    .clk_i      (clk_i),
    .load_i     (cmd_i.wrap),
    .step_i     (cmd_i.div_step),
    .dividend_i (opos_w),
    .divisor_i  (width_q),
    .quot_o     (y),
    .rem_o      (x)
  );

  // shared tap multiplier: row pass over the window, then column pass over the store
  assign rsum_row = acc_row_q + ACC_W'(HALF);
  assign hval     = rsum_row[PIX_W+15:16];
  assign rsum_col = acc_col_q + ACC_W'(HALF);

  always_comb begin
    if (cmd_i.row_step) begin
      mul_a = tap(cmd_i.idx);
      mul_b = (cmd_i.idx < IDX_W'(STORE_ROWS)) ? win_q[cmd_i.idx[ROW_W-1:0]] : sample_q;
    end else if (cmd_i.idx == '0) begin
      mul_a = tap(IDX_W'(TAPS - 1));
      mul_b = hval;
    end else begin
      mul_a = tap(cmd_i.idx - IDX_W'(1));
      mul_b = rd_q;
    end
    prod = mul_a * mul_b;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_step)
      acc_row_q <= ((cmd_i.idx == '0) ? '0 : acc_row_q) + ACC_W'(prod);
    if (cmd_i.col_step)
      acc_col_q <= ((cmd_i.idx == '0) ? '0 : acc_col_q) + ACC_W'(prod);
  end

  // column pass reads rows r..r+15 of the ring, one per cycle
  assign rrow  = r[ROW_W-1:0] + cmd_i.idx[ROW_W-1:0];
  assign raddr = A_W'(rrow) * A_W'(MAX_WIDTH) + A_W'(x);
  assign hx    = c - W_W'(RADIUS);
  assign waddr = A_W'(r[ROW_W-1:0]) * A_W'(MAX_WIDTH) + A_W'(hx);

  assign is_pix = (op_q == OP_PIXEL);
  assign h_ok   = is_pix && (c >= W_W'(2 * RADIUS));
  assign bl_inc = backlog_q + P_W'(is_pix);
  assign emit   = is_pix ? (bl_inc > lag_q) : (backlog_q != '0);
  assign inner  = (y >= P_W'(RADIUS)) && (y < P_W'(height_q) - P_W'(RADIUS)) &&
                  (x >= W_W'(RADIUS)) && (x < width_q - W_W'(RADIUS));
  assign filt   = inner && h_ok && (r == y + P_W'(RADIUS)) && (hx == x);

  always_ff @(posedge clk_i) begin
    rd_q <= store_q[raddr];
    if (cmd_i.fin && h_ok)
      store_q[waddr] <= hval;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ipos_q      <= '0;
      opos_q      <= '0;
      backlog_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < STORE_ROWS; i++) win_q[i] <= '0;
    end else begin
      if (cmd_i.wrap) begin
        ipos_q <= ipos_w;
        opos_q <= opos_w;
      end
      if (out_valid_q && !out_stall_i)
        out_valid_q <= 1'b0;
      if (cmd_i.fin) begin
        if (is_pix) begin
          for (int i = 0; i < STORE_ROWS - 1; i++) win_q[i] <= win_q[i+1];
          win_q[STORE_ROWS-1] <= sample_q;
          ipos_q <= (ipos_q + P_W'(1) == total_q) ? '0 : ipos_q + P_W'(1);
        end
        if (emit) begin
          out_valid_q <= 1'b1;
          opos_q      <= (opos_q + P_W'(1) == total_q) ? '0 : opos_q + P_W'(1);
          backlog_q   <= bl_inc - P_W'(1);
        end else begin
          backlog_q   <= bl_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin && emit) begin
      out_q.row   <= 8'(y);
      out_q.col   <= 8'(x);
      out_q.value <= filt ? rsum_col[PIX_W+15:16] : border_q;
      out_q.last  <= (opos_q == total_q - P_W'(1));
    end
  end

  assign sts_o.out_free = out_free;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

[src/sgs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgs_ctrl
// Sequencer: accept, size prep, position split, row pass, column pass, finish.
// ----------------------------------------------------------------------------
module sgs_ctrl #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sgs_pkg::dp_sts_t   sts_i,
  output sgs_pkg::ctrl_cmd_t cmd_o
);
  import sgs_pkg::*;

  localparam int P_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_WRAP = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_ROW  = 3'd4;
  localparam logic [2:0] S_COL  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.idx = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_WRAP;
      end
      S_WRAP: begin
        cmd_o.wrap = 1'b1;
        cnt_d      = '0;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + IDX_W'(1);
        if (cnt_q == IDX_W'(P_W - 1)) begin
          cnt_d   = '0;
          state_d = S_ROW;
        end
      end
      S_ROW: begin
        cmd_o.row_step = 1'b1;
        cnt_d = cnt_q + IDX_W'(1);
        if (cnt_q == IDX_W'(TAPS - 1)) begin
          cnt_d   = '0;
          state_d = S_COL;
        end
      end
      S_COL: begin
        cmd_o.col_step = 1'b1;
        cnt_d = cnt_q + IDX_W'(1);
        if (cnt_q == IDX_W'(TAPS - 1)) begin
          cnt_d   = '0;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // wait for room in the output register
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

[src/separable_gaussian_smoothing.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_gaussian_smoothing
// 17-tap separable gaussian on a 16-bit raster stream, row then column pass.
// ----------------------------------------------------------------------------
//  channel | signals                            | beat
//  in      | in_valid_i, in_stall_o, in_data_i   | op, sample
//  out     | out_valid_o, out_stall_i, out_data_o| row, col, value, last
//  cfg     | cfg_we_i, cfg_index_i, cfg_data_i   | width, height, border
//
// one item at a time, paced by the bit-serial position split and the single
// shared tap multiplier, which walks the window and then the row store; no
// new beat is taken until the item before it has finished.
// reset clears positions, backlog and the pixel window; the row store is not
// cleared. a result waits in the output register while the next beat is taken;
// a finished item holds only if that register is still full and stalled.
// ----------------------------------------------------------------------------
module separable_gaussian_smoothing #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sgs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sgs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sgs_pkg::in_beat_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sgs_pkg::out_beat_t              out_data_o
);
  import sgs_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  sgs_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sgs_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("accepted a beat while an item is in flight");

  a_fin_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin |-> sts.out_free)
    else $error("finish issued with output register full and stalled");

  a_one_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.prep, cmd.wrap, cmd.div_step, cmd.row_step,
              cmd.col_step, cmd.fin}))
    else $error("more than one datapath command at once");

  a_idle_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin |=> !in_stall_o)
    else $error("sequencer not idle after finishing an item");

endmodule

[tb/sv/sgs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgs_checker
// Watches the config port and both channels of the gaussian smoother, keeps
// its own copy of the two-pass filter state, predicts each result beat and
// compares it field by field with the beats that leave the block.
// ----------------------------------------------------------------------------
module sgs_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  sgs_pkg::in_beat_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  sgs_pkg::out_beat_t out_data_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 backlog_o
);
  import sgs_pkg::*;

  localparam int R = 8;

  const int unsigned gauss_taps [17] = '{
    915, 1462, 2195, 3095, 4100, 5103, 5966, 6552, 6760,
    6552, 5966, 5103, 4100, 3095, 2195, 1462, 915
  };

  out_beat_t   smoothed_q [$];
  logic [15:0] row_sums [16][256];
  logic [15:0] pix_hist [16];
  int unsigned pix_pos, res_pos, owed;
  int unsigned img_w, img_h;
  logic [15:0] edge_val;
  int          errors;

  assign errors_o  = errors;
  assign pending_o = smoothed_q.size();
  assign backlog_o = owed;

  function automatic int unsigned clamp_dim(logic [8:0] v);
    if (v < 17) return 17;
    if (v > 256) return 256;
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned total, lag, r, c, hx, y, x, acc;
    logic [15:0] hval, s;
    logic        h_ok, emit, inner;
    out_beat_t   exp_b, got;
    if (!rst_ni) begin
      smoothed_q.delete();
      foreach (pix_hist[i]) pix_hist[i] = '0;
      pix_pos  = 0;
      res_pos  = 0;
      owed     = 0;
      img_w    = 256;
      img_h    = 256;
      edge_val = 16'd1;
      errors   = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (smoothed_q.size() == 0) begin
          $display("%0t: unexpected result beat row %0d col %0d value %0d last %0d",
                   $realtime, got.row, got.col, got.value, got.last);
          errors++;
        end else begin
          exp_b = smoothed_q.pop_front();
          if (got.row !== exp_b.row) begin
            $display("%0t: row expected %0d actual %0d", $realtime, exp_b.row, got.row);
            errors++;
          end
          if (got.col !== exp_b.col) begin
            $display("%0t: col expected %0d actual %0d", $realtime, exp_b.col, got.col);
            errors++;
          end
          if (got.value !== exp_b.value) begin
            $display("%0t: value at (%0d,%0d) expected %0d actual %0d", $realtime,
                     exp_b.row, exp_b.col, exp_b.value, got.value);
            errors++;
          end
          if (got.last !== exp_b.last) begin
            $display("%0t: last expected %0d actual %0d", $realtime, exp_b.last, got.last);
            errors++;
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_WIDTH:  img_w = clamp_dim(cfg_data_i[8:0]);
          REG_HEIGHT: img_h = clamp_dim(cfg_data_i[8:0]);
          REG_BORDER: edge_val = cfg_data_i;
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        total = img_w * img_h;
        lag   = R * img_w + R;
        if (pix_pos >= total) pix_pos = 0;
        if (res_pos >= total) res_pos = 0;
        h_ok = 1'b0;
        r = 0; hx = 0; hval = '0;
        if (in_data_i.op == OP_PIXEL) begin
          s = in_data_i.sample;
          r = pix_pos / img_w;
          c = pix_pos % img_w;
          if (c >= 2 * R) begin
            acc = gauss_taps[16] * s;
            for (int k = 0; k < 16; k++) acc += gauss_taps[k] * pix_hist[k];
            hval = 16'((acc + 32768) >> 16);
            hx   = c - R;
            h_ok = 1'b1;
          end
          for (int k = 0; k < 15; k++) pix_hist[k] = pix_hist[k+1];
          pix_hist[15] = s;
          owed++;
          pix_pos++;
          if (pix_pos >= total) pix_pos = 0;
          emit = owed > lag;
        end else begin
          emit = owed > 0;
        end

        if (emit) begin
          y = res_pos / img_w;
          x = res_pos % img_w;
          exp_b.value = edge_val;
          inner = y >= R && y < img_h - R && x >= R && x < img_w - R;
          // only the beat whose pixel sits a radius below and right gets filtered
          if (inner && h_ok && r == y + R && hx == x) begin
            acc = gauss_taps[16] * hval;
            for (int k = 0; k < 16; k++)
              acc += gauss_taps[k] * row_sums[(r + k) % 16][x];
            exp_b.value = 16'((acc + 32768) >> 16);
          end
          exp_b.row  = y[7:0];
          exp_b.col  = x[7:0];
          exp_b.last = (res_pos == total - 1);
          smoothed_q.push_back(exp_b);
          owed--;
          res_pos++;
          if (res_pos >= total) res_pos = 0;
        end

        if (h_ok) row_sums[r % 16][hx] = hval;
      end
    end
  end

endmodule

[tb/sv/tb_separable_gaussian_smoothing.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_separable_gaussian_smoothing
// Drives whole frames of random pixels with scattered flushes through the
// smoother under several sizes and border values, drains each frame with
// flushes, and takes the verdict from the checker beside the block.
// ----------------------------------------------------------------------------
module tb_separable_gaussian_smoothing;
  import sgs_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;
  int        errors, pending, backlog;
  int        send_idle_pct = 0;
  int        stall_pct = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  separable_gaussian_smoothing dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  sgs_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .errors_o(errors), .pending_o(pending), .backlog_o(backlog)
  );

  always @(posedge clk_i) out_stall <= ($urandom_range(99) < stall_pct);

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_beat(logic op, logic [15:0] smp);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{op: op, sample: smp};
    do @(posedge clk_i); while (in_stall);
  endtask

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  // one whole frame, then flushes until nothing is owed, then a settle pause
  task automatic run_frame(int w, int h, int flush_pct);
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(99) < flush_pct) send_beat(OP_FLUSH, 16'($urandom_range(16'hFFFF)));
      send_beat(OP_PIXEL, rand_pixel());
    end
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (backlog > 0) begin
      send_beat(OP_FLUSH, 16'($urandom_range(16'hFFFF)));
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_size(logic [15:0] w, logic [15:0] h, logic [15:0] bv);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_BORDER, bv);
  endtask

  initial begin
    int w, h;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // undersized width saturates up to the minimum, bits above 9 dropped
    send_idle_pct = 12;
    stall_pct     = 62;
    set_size(16'd3, 16'hFE11, 16'd0);
    write_reg(2'd3, 16'hFFFF);
    // flush with nothing owed, then a whole 17x17 frame of extreme pixels
    send_beat(OP_FLUSH, 16'hFFFF);
    for (int i = 0; i < 17 * 17; i++) send_beat(OP_PIXEL, (i % 2) ? 16'hFFFF : 16'h0000);
    send_beat(OP_FLUSH, 16'h0000);
    send_beat(OP_FLUSH, 16'h5A5A);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (backlog > 0) begin
      send_beat(OP_FLUSH, 16'h0);
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    for (int f = 0; f < 3; f++) begin
      if (f == 2) begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end else if (f == 1) begin
        send_idle_pct = 62;
        stall_pct     = 12;
      end
      w = $urandom_range(17, 22);
      h = $urandom_range(17, 20);
      set_size(16'(w), 16'(h), rand_pixel());
      run_frame(w, h, 2);
    end

    if (errors == 0 && pending == 0) begin
      $display("separable_gaussian_smoothing verification clean");
    end else begin
      $display("separable_gaussian_smoothing verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("separable_gaussian_smoothing verification failed");
    $finish;
  end

endmodule
